>>> design/pool_pkg.sv
// ----------------------------------------------------------------------------
// pool_pkg: shared constants and types for 2-D pooling
// Register indexes, size limits and controller state type.
// ----------------------------------------------------------------------------
package pool_pkg;
	localparam int MAX_COLS    = 256;
	localparam int MAX_ROWS    = 256;
	localparam int MAX_WINDOW  = 4;
	localparam int MAX_PLANES  = 512;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_STEP    = 7;

	localparam logic [2:0] REG_HEIGHT   = 3'd0;
	localparam logic [2:0] REG_WIDTH    = 3'd1;
	localparam logic [2:0] REG_CHANNELS = 3'd2;
	localparam logic [2:0] REG_WSIZE    = 3'd3;
	localparam logic [2:0] REG_WSTEP    = 3'd4;
	localparam logic [2:0] REG_AVG      = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_OUT
	} pool_state_t;
endpackage

>>> design/pool2d_max_avg.sv
// ----------------------------------------------------------------------------
// pool2d_max_avg: streaming 2-D max / average pooling
// Line store in banked RAM, one window column read per cycle.
// ----------------------------------------------------------------------------
// Use: samples arrive on sample/in_valid/in_ready in raster order, plane after
// plane. Each sample is written to one of MAX_WINDOW row banks. A sample that
// closes no window is taken at once, back to back. A sample that closes a
// window starts a scan: one window column (all rows, one bank each) is read per
// cycle through the registered RAM read. Average mode then adds a reciprocal
// multiply by 1/window_size^2. The output state then hands the result to the
// output register, after which the next request is taken. The result appears on
// pooled/out_row/out_col/out_channel/frame_last with out_valid/out_ready. A
// stalled receiver holds the output register; the input stalls from the start
// of a scan until its result is handed over to the output register.
// Reset clears positions and loads the default registers; the line store holds
// no reset value. A write to any register index up to REG_AVG restarts the
// frame.
// ----------------------------------------------------------------------------
module pool2d_max_avg #(
	parameter int MAX_COLS    = pool_pkg::MAX_COLS,
	parameter int MAX_ROWS    = pool_pkg::MAX_ROWS,
	parameter int MAX_WINDOW  = pool_pkg::MAX_WINDOW,
	parameter int MAX_PLANES  = pool_pkg::MAX_PLANES,
	parameter int SAMPLE_BITS = pool_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [9:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] pooled,
	output logic [7:0]                    out_row,
	output logic [7:0]                    out_col,
	output logic [8:0]                    out_channel,
	output logic                          frame_last
);
	import pool_pkg::*;

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RB  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WW  = $clog2(MAX_WINDOW + 1);
	localparam int ACW = SAMPLE_BITS + 2 * WW + 1;
	localparam int DVW = 2 * WW;
	localparam int RK  = ACW + DVW;
	localparam int RKW = RK + 1;
	localparam int PW  = ACW + RKW;

	logic [8:0] h_q, w_q;
	logic [9:0] ch_q;
	logic [2:0] ws_q, st_q;
	logic       avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= 9'd8; w_q <= 9'd8; ch_q <= 10'd1;
			ws_q <= 3'd2; st_q <= 3'd2; avg_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEIGHT:   h_q <= cfg_data[8:0];
				REG_WIDTH:    w_q <= cfg_data[8:0];
				REG_CHANNELS: ch_q <= cfg_data;
				REG_WSIZE:    ws_q <= cfg_data[2:0];
				REG_WSTEP:    st_q <= cfg_data[2:0];
				REG_AVG:      avg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped register values
	logic [12:0] hc, wc, chc;
	logic [3:0]  wsc, stc;
	always_comb begin
		hc  = (h_q == 9'd0) ? 13'd1 :
			(13'(h_q) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(h_q);
		wc  = (w_q == 9'd0) ? 13'd1 :
			(13'(w_q) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(w_q);
		chc = (ch_q == 10'd0) ? 13'd1 :
			(13'(ch_q) > 13'(MAX_PLANES)) ? 13'(MAX_PLANES) : 13'(ch_q);
		wsc = (ws_q == 3'd0) ? 4'd1 :
			(4'(ws_q) > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : 4'(ws_q);
		stc = (st_q == 3'd0) ? 4'd1 : 4'(st_q);
	end

	// position counters; phase counters replace the modulo by stride
	logic [12:0] r_q, c_q, chp_q;
	logic [3:0]  rph_q, cph_q;
	logic [12:0] r_e, c_e, chp_e;
	logic [3:0]  rph_e, cph_e;

	always_comb begin
		if (r_q >= hc || c_q >= wc || chp_q >= chc) begin
			r_e = '0; c_e = '0; chp_e = '0; rph_e = '0; cph_e = '0;
		end else begin
			r_e = r_q; c_e = c_q; chp_e = chp_q; rph_e = rph_q; cph_e = cph_q;
		end
	end

	pool_state_t state_q, state_d;
	logic accept;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// closes when r+1, c+1 >= ws and phases (r+1-ws, c+1-ws mod st) are 0
	logic [12:0] r1, c1;
	logic hit;
	assign r1 = r_e + 13'd1;
	assign c1 = c_e + 13'd1;
	assign hit = (r1 >= 13'(wsc)) && (c1 >= 13'(wsc)) &&
		(rph_e == 4'd0) && (cph_e == 4'd0);

	// output indexes: count of windows so far
	logic [7:0] orow_q, ocol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0; c_q <= '0; chp_q <= '0; rph_q <= '0; cph_q <= '0;
			orow_q <= '0; ocol_q <= '0;
		end else if (cfg_we && cfg_index <= REG_AVG) begin
			r_q <= '0; c_q <= '0; chp_q <= '0; rph_q <= '0; cph_q <= '0;
			orow_q <= '0; ocol_q <= '0;
		end else if (accept) begin
			if (c1 >= wc) begin
				c_q <= '0; cph_q <= '0; ocol_q <= '0;
				if (r1 >= hc) begin
					r_q <= '0; rph_q <= '0; orow_q <= '0;
					chp_q <= (chp_e + 13'd1 >= chc) ? 13'd0 : chp_e + 13'd1;
				end else begin
					r_q <= r1; chp_q <= chp_e;
					if (r1 >= 13'(wsc)) begin
						if (rph_e == 4'd0) orow_q <= orow_q + 8'd1;
						rph_q <= (rph_e + 4'd1 >= stc) ? 4'd0 : rph_e + 4'd1;
					end else begin
						rph_q <= '0;
					end
				end
			end else begin
				c_q <= c1; r_q <= r_e; chp_q <= chp_e; rph_q <= rph_e;
				if (c1 >= 13'(wsc)) begin
					if (cph_e == 4'd0) ocol_q <= ocol_q + 8'd1;
					cph_q <= (cph_e + 4'd1 >= stc) ? 4'd0 : cph_e + 4'd1;
				end else begin
					cph_q <= '0;
				end
			end
		end
	end

	// banked line store: bank = row % MAX_WINDOW
	logic [RB-1:0]          wbank;
	logic [MAX_WINDOW-1:0]  bank_we;
	logic [CW-1:0]          raddr;
	logic [SAMPLE_BITS-1:0] rdata [MAX_WINDOW];
	assign wbank = RB'(r_e % 13'(MAX_WINDOW));

	genvar gb;
	generate
		for (gb = 0; gb < MAX_WINDOW; gb++) begin : g_bank
			assign bank_we[gb] = accept && (wbank == RB'(gb));
			pool_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS)) u_ram (
				.clk   (clk),
				.we    (bank_we[gb]),
				.waddr (c_e[CW-1:0]),
				.wdata (sample),
				.raddr (raddr),
				.rdata (rdata[gb])
			);
		end
	endgenerate

	// ceil(2^RK / n^2); exact truncation for every window sum magnitude
	function automatic logic [RKW-1:0] recip_of(input logic [3:0] n);
		logic [RKW-1:0] r;
		r = '0;
		for (int d = 1; d <= MAX_WINDOW; d++) begin
			if (n == 4'(d))
				r = RKW'(((64'd1 << RK) + 64'(d * d) - 64'd1) / 64'(d * d));
		end
		return r;
	endfunction

	// scan registers
	logic [CW-1:0] left_q;
	logic [RB-1:0] topb_q;
	logic [3:0]    col_q;
	logic          rv_s1;
	logic [3:0]    rcol_s1;
	logic signed [ACW-1:0] acc_q;
	logic signed [SAMPLE_BITS-1:0] best_q;
	logic          first_q;
	logic [7:0]    orow_r_q, ocol_r_q;
	logic [8:0]    och_q;
	logic          last_q;
	logic [ACW-1:0] quo_q;
	logic          neg_q;
	logic [RKW-1:0] recip_q;

	assign raddr = left_q + CW'(col_q);

	// column sum / max over the window rows
	logic signed [ACW-1:0] colsum;
	logic signed [SAMPLE_BITS-1:0] colmax;
	logic colany;
	always_comb begin
		logic [RB:0] b;
		colsum = '0; colmax = '0; colany = 1'b0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			b = {1'b0, topb_q} + (RB+1)'(i);
			if (b >= (RB+1)'(MAX_WINDOW)) b = b - (RB+1)'(MAX_WINDOW);
			if (4'(i) < wsc) begin
				colsum = colsum + ACW'($signed(rdata[b[RB-1:0]]));
				if (!colany || $signed(rdata[b[RB-1:0]]) > colmax)
					colmax = $signed(rdata[b[RB-1:0]]);
				colany = 1'b1;
			end
		end
	end

	// output register
	logic ov_q;
	logic load_out;
	logic signed [SAMPLE_BITS-1:0] pooled_q;
	logic [7:0] orow_o_q, ocol_o_q;
	logic [8:0] och_o_q;
	logic       last_o_q;
	assign load_out = (state_q == ST_OUT) && (!ov_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && hit) state_d = ST_READ;
			ST_READ: if (rv_s1 && rcol_s1 + 4'd1 >= wsc)
				state_d = avg_q ? ST_DIV : ST_OUT;
			ST_DIV:  state_d = ST_OUT;
			ST_OUT:  if (!ov_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1 <= (state_q == ST_READ) && (col_q < wsc);
			if (load_out) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	logic [ACW-1:0] acc_fin;
	logic [PW-1:0]  prod;
	assign acc_fin = acc_q + colsum;
	assign prod = PW'(quo_q) * PW'(recip_q);

	always_ff @(posedge clk) begin
		rcol_s1 <= col_q;
		case (state_q)
			ST_IDLE: begin
				left_q   <= CW'(c1 - 13'(wsc));
				topb_q   <= RB'((r1 - 13'(wsc)) % 13'(MAX_WINDOW));
				col_q    <= '0;
				acc_q    <= '0;
				first_q  <= 1'b1;
				orow_r_q <= orow_q;
				ocol_r_q <= ocol_q;
				och_q    <= chp_e[8:0];
				last_q   <= (chp_e + 13'd1 == chc) && (r_e + 13'(stc) >= hc) &&
					(c_e + 13'(stc) >= wc);
				recip_q  <= recip_of(wsc);
			end
			ST_READ: begin
				if (col_q < wsc) col_q <= col_q + 4'd1;
				if (rv_s1) begin
					acc_q <= acc_fin;
					if (first_q || colmax > best_q) best_q <= colmax;
					first_q <= 1'b0;
					neg_q <= acc_fin[ACW-1];
					quo_q <= acc_fin[ACW-1] ? -acc_fin : acc_fin;
				end
			end
			ST_DIV: begin
				quo_q <= prod[RK +: ACW];
			end
			default: ;
		endcase
	end

	logic [ACW-1:0] qs;
	assign qs = neg_q ? -quo_q : quo_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			pooled_q <= avg_q ? qs[SAMPLE_BITS-1:0] : best_q;
			orow_o_q <= orow_r_q;
			ocol_o_q <= ocol_r_q;
			och_o_q  <= och_q;
			last_o_q <= last_q;
		end
	end

	assign out_valid   = ov_q;
	assign pooled      = pooled_q;
	assign out_row     = orow_o_q;
	assign out_col     = ocol_o_q;
	assign out_channel = och_o_q;
	assign frame_last  = last_o_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	a_hit_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit && !cfg_we) |=> (state_q == ST_READ)) else $error("no scan");
endmodule

>>> design/pool_ram.sv
// ----------------------------------------------------------------------------
// pool_ram: generic single-port-write, single-port-read RAM
// Registered read: the word at raddr appears on rdata in the next cycle.
// ----------------------------------------------------------------------------
module pool_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
